### rtl/pce_pkg.sv
package pce_pkg;

    typedef logic [7:0] lut_t [256];

    localparam int CH_W   = 8;
    localparam int NUM_W  = 19;
    localparam int DEN_W  = 10;
    localparam int DIV_STAGES = 4;

    localparam logic [2:0] MODE_SEPIA   = 3'd0;
    localparam logic [2:0] MODE_CASTING = 3'd1;
    localparam logic [2:0] MODE_FREEZE  = 3'd2;
    localparam logic [2:0] MODE_INVERT  = 3'd3;
    localparam logic [2:0] MODE_HARD    = 3'd4;
    localparam logic [2:0] MODE_SOFT    = 3'd5;

    localparam logic [DEN_W-1:0] SEPIA_DEN = DEN_W'(1000);

    function automatic longint isqrt_f(longint v);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = 131072;
        for (int i = 0; i < 20; i++)
        begin
            if (hi - lo > 1)
            begin
                mid = (lo + hi) >> 1;
                if (mid * mid <= v)
                    lo = mid;
                else
                    hi = mid;
            end
        end
        return lo;
    endfunction

    function automatic logic [7:0] sat_f(longint v);
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function automatic lut_t build_hard();
        lut_t t;
        longint r;
        for (int x = 0; x < 256; x++)
        begin
            r = x;
            if (r <= 127)
                t[x] = sat_f((2 * r * r) / 255);
            else
                t[x] = sat_f((255 * r + (255 - r) * (2 * r - 255)) / 255);
        end
        return t;
    endfunction

    function automatic lut_t build_soft();
        lut_t t;
        longint r;
        longint p;
        longint q;
        longint qs;
        for (int x = 0; x < 256; x++)
        begin
            r = x;
            if (r <= 127)
                t[x] = sat_f((r * r * (765 - 2 * r)) / 65025);
            else
            begin
                p = 2 * r * (255 - r);
                q = 2 * r - 255;
                qs = isqrt_f(q * q * 255 * r);
                t[x] = sat_f((p + qs) / 255);
            end
        end
        return t;
    endfunction

    localparam lut_t HARD_TBL = build_hard();
    localparam lut_t SOFT_TBL = build_soft();

endpackage

### rtl/pce_div_lane.sv
module pce_div_lane (
    input  logic                        clk,
    input  logic [pce_pkg::DIV_STAGES:0] en,
    input  logic [pce_pkg::NUM_W-1:0]   num,
    input  logic [pce_pkg::DEN_W-1:0]   den,
    input  logic                        sat,
    input  logic                        use_div,
    input  logic [pce_pkg::CH_W-1:0]    direct,
    output logic [pce_pkg::CH_W-1:0]    result
);
    import pce_pkg::*;

    logic [NUM_W-1:0] rem_reg    [DIV_STAGES];
    logic [CH_W-1:0]  q_reg      [DIV_STAGES];
    logic [DEN_W-1:0] den_reg    [DIV_STAGES];
    logic             sat_reg    [DIV_STAGES];
    logic             div_reg    [DIV_STAGES];
    logic [CH_W-1:0]  direct_reg [DIV_STAGES];
    logic [CH_W-1:0]  result_reg;

    logic [NUM_W-1:0] rem_next [DIV_STAGES];
    logic [CH_W-1:0]  q_next   [DIV_STAGES];
    logic [CH_W-1:0]  result_next;

    // two quotient bits per stage, restoring
    always_comb
    begin
        logic [NUM_W-1:0] r;
        logic [NUM_W-1:0] t;
        logic [CH_W-1:0]  q;
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            r = rem_reg[j];
            q = q_reg[j];
            for (int k = 1; k >= 0; k--)
            begin
                t = NUM_W'(den_reg[j]) << (CH_W - 2 - 2 * j + k);
                if (r >= t)
                begin
                    r = r - t;
                    q[CH_W - 2 - 2 * j + k] = 1'b1;
                end
            end
            rem_next[j] = r;
            q_next[j]   = q;
        end
        if (!div_reg[DIV_STAGES-1])
            result_next = direct_reg[DIV_STAGES-1];
        else if (sat_reg[DIV_STAGES-1])
            result_next = 8'd255;
        else
            result_next = q_next[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0]    <= num;
            q_reg[0]      <= '0;
            den_reg[0]    <= den;
            sat_reg[0]    <= sat;
            div_reg[0]    <= use_div;
            direct_reg[0] <= direct;
        end
        for (int j = 1; j < DIV_STAGES; j++)
        begin
            if (en[j])
            begin
                rem_reg[j]    <= rem_next[j-1];
                q_reg[j]      <= q_next[j-1];
                den_reg[j]    <= den_reg[j-1];
                sat_reg[j]    <= sat_reg[j-1];
                div_reg[j]    <= div_reg[j-1];
                direct_reg[j] <= direct_reg[j-1];
            end
        end
        if (en[DIV_STAGES])
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

### rtl/pixel_color_effect.sv
// each accepted input passes through the divider stage registers and then the result register
// throughput: one pixel per cycle while out_stall is low; each stage moves on when it is empty or the
//   next stage moves, so bubbles close up under a stalled output
// reset: rst_n clears all stage valid bits and sets effect_mode to sepia;
//   datapath registers are not reset
module pixel_color_effect (
    input  logic       clk,
    input  logic       rst_n,
    // configuration port
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready,
    // input pixel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_blue,
    input  logic [7:0] in_green,
    input  logic [7:0] in_red,
    // result pixel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_blue,
    output logic [7:0] out_green,
    output logic [7:0] out_red
);
    import pce_pkg::*;

    localparam int NST = DIV_STAGES + 1;

    logic [2:0]     mode_reg;
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST:0]   adv;

    // register file: effect_mode at byte addresses 0 to 3 (paddr[2] low); addresses 4 to 7 read zero and ignore writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_SEPIA;
        else if (psel && penable && pwrite && !paddr[2])
            mode_reg <= pwdata[2:0];
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {29'd0, mode_reg};

    // stage k moves when it is empty or stage k+1 moves
    always_comb
    begin
        adv[NST] = !out_stall;
        for (int k = NST - 1; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
        vld_next = vld_reg;
        for (int k = 0; k < NST; k++)
        begin
            if (adv[k])
                vld_next[k] = (k == 0) ? in_valid : vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign in_stall  = !adv[0];
    assign out_valid = vld_reg[NST-1];

    // per-lane operands; lane 0 blue, 1 green, 2 red
    logic [CH_W-1:0]  px     [3];
    logic [NUM_W-1:0] num    [3];
    logic [DEN_W-1:0] den    [3];
    logic             sat    [3];
    logic             use_div;
    logic [CH_W-1:0]  direct [3];
    logic [CH_W-1:0]  res    [3];

    assign px[0] = in_blue;
    assign px[1] = in_green;
    assign px[2] = in_red;

    always_comb
    begin
        logic [CH_W:0]     osum;
        logic signed [10:0] d;
        logic [10:0]       mag;
        logic [10:0]       half;
        logic [NUM_W-1:0]  sep [3];
        sep[0] = NUM_W'(272 * in_red) + NUM_W'(534 * in_green) + NUM_W'(131 * in_blue);
        sep[1] = NUM_W'(349 * in_red) + NUM_W'(686 * in_green) + NUM_W'(168 * in_blue);
        sep[2] = NUM_W'(393 * in_red) + NUM_W'(769 * in_green) + NUM_W'(189 * in_blue);
        use_div = (mode_reg == MODE_SEPIA) || (mode_reg == MODE_CASTING);
        for (int i = 0; i < 3; i++)
        begin
            osum = {1'b0, px[(i+1)%3]} + {1'b0, px[(i+2)%3]};
            d    = $signed({3'b000, px[i]}) - $signed({2'b00, osum});
            mag  = (d < 0) ? 11'(-d) : 11'(d);
            mag  = 11'(mag * 3);
            half = mag >> 1;
            if (mode_reg == MODE_SEPIA)
            begin
                num[i] = sep[i];
                den[i] = SEPIA_DEN;
            end
            else
            begin
                num[i] = NUM_W'(px[i] * 255);
                den[i] = DEN_W'(osum) + DEN_W'(1);
            end
            sat[i] = num[i] >= (NUM_W'(den[i]) << CH_W);
            unique case (mode_reg)
                MODE_FREEZE: direct[i] = (half > 11'd255) ? 8'd255 : half[7:0];
                MODE_INVERT: direct[i] = 8'd255 - px[i];
                MODE_HARD:   direct[i] = HARD_TBL[px[i]];
                MODE_SOFT:   direct[i] = SOFT_TBL[px[i]];
                default:     direct[i] = px[i];
            endcase
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        pce_div_lane u_lane (
            .clk     (clk),
            .en      (adv[NST-1:0]),
            .num     (num[i]),
            .den     (den[i]),
            .sat     (sat[i]),
            .use_div (use_div),
            .direct  (direct[i]),
            .result  (res[i])
        );
    end

    assign out_blue  = res[0];
    assign out_green = res[1];
    assign out_red   = res[2];

endmodule

### rtl/pce_checker.sv
module pce_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_blue,
    input logic [7:0] out_green,
    input logic [7:0] out_red
);
    logic [3:0] occ_reg;
    logic [3:0] occ_next;
    logic       acc_in;
    logic       acc_out;

    assign acc_in  = in_valid && !in_stall;
    assign acc_out = out_valid && !out_stall;

    always_comb
    begin
        occ_next = occ_reg + 4'(acc_in) - 4'(acc_out);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else
            occ_reg <= occ_next;
    end

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output valid dropped under stall");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_blue) && $stable(out_green)
            && $stable(out_red))
        else $error("output payload changed under stall");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != 4'd0)
        else $error("output transaction without input transaction");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= 4'd5)
        else $error("more transactions in flight than pipeline stages");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == 4'd5 && out_stall |-> in_stall)
        else $error("input accepted while pipeline full");

endmodule

bind pixel_color_effect pce_checker u_pce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_blue  (out_blue),
    .out_green (out_green),
    .out_red   (out_red)
);
